FILE: design/trle_pkg.sv
package trle_pkg;

   localparam int MAX_RUN_DEF   = 127;
   localparam int BYTES_DEF     = 8;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 7;
   localparam int CNT_W         = 4;
   localparam int OUT_BYTES     = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int PTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [BYTE_W-1:0] TRANS_FLAG = 8'h80;
   localparam logic [BYTE_W-1:0] ROW_MARK   = 8'h80;

   typedef enum logic [1:0] {
      CLOSE_NONE   = 2'd0,
      CLOSE_TRANS  = 2'd1,
      CLOSE_OPAQUE = 2'd2
   } close_kind_type;

   // Everything one accepted pixel asks the back end to emit.
   typedef struct packed {
      close_kind_type     pre_kind;
      logic [LEN_W-1:0]   pre_len;
      logic               pre_bank;
      logic               row_run;
      logic [LEN_W-1:0]   row_len;
      logic               row_bank;
      logic               marker;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_free_type;

endpackage

FILE: design/trle_ifs.sv
interface trle_req_if import trle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel;
   logic              row_end;

   modport source (output valid, pixel, row_end, input ready);
   modport sink   (input valid, pixel, row_end, output ready);
endinterface

interface trle_rsp_if import trle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_0;
   logic [BYTE_W-1:0] byte_1;
   logic [BYTE_W-1:0] byte_2;
   logic [BYTE_W-1:0] byte_3;
   logic [BYTE_W-1:0] byte_4;
   logic [BYTE_W-1:0] byte_5;
   logic [BYTE_W-1:0] byte_6;
   logic [BYTE_W-1:0] byte_7;
   logic [CNT_W-1:0]  byte_count;
   logic              last;

   modport source (output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6,
                   byte_7, byte_count, last, input ready);
   modport sink   (input valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6,
                   byte_7, byte_count, last, output ready);
endinterface

FILE: design/trle_ram.sv
module trle_ram import trle_pkg::*; #(
   parameter int IDX_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W:0]    wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [IDX_W:0]    rd_addr,
   output logic [BYTE_W-1:0] rd_data_ff
);

   localparam int DEPTH = 2 ** (IDX_W + 1);

   logic [BYTE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

FILE: design/trle_fifo.sv
module trle_fifo import trle_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  job_type         push_job,
   input  logic            pop,
   output job_type         head_job,
   output fifo_status_type status
);

   job_type            q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head_job     = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/trle_front.sv
module trle_front import trle_pkg::*; #(
   parameter int MAX_RUN = MAX_RUN_DEF,
   parameter int IDX_W   = 7
) (
   input  logic              clock,
   input  logic              reset,
   trle_req_if.sink          req_ch,
   input  fifo_status_type   q_status,
   input  bank_free_type     bank_free,
   output logic              job_push,
   output job_type           job,
   output logic              wr_en,
   output logic [IDX_W:0]    wr_addr,
   output logic [BYTE_W-1:0] wr_data
);

   logic              run_trans_ff, run_trans_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              trans;
   logic              close_pre;
   logic              opaque_close;
   logic              bank_after;
   logic [LEN_W-1:0]  base_len;
   logic [LEN_W-1:0]  new_len;
   logic              accept;

   always_comb begin
      trans        = (req_ch.pixel == '0);
      close_pre    = (len_ff != '0) &&
                     ((run_trans_ff != trans) || (len_ff >= LEN_W'(MAX_RUN)));
      opaque_close = close_pre && !run_trans_ff;
      // An opaque run that closes hands its bank to the back end.
      bank_after   = opaque_close ? ~bank_ff : bank_ff;
      base_len     = close_pre ? '0 : len_ff;
      new_len      = base_len + LEN_W'(1);

      req_ch.ready = !q_status.full && !(!trans && busy_ff[bank_after]);
      accept       = req_ch.valid && req_ch.ready;

      job.pre_kind = !close_pre ? CLOSE_NONE : (run_trans_ff ? CLOSE_TRANS : CLOSE_OPAQUE);
      job.pre_len  = len_ff;
      job.pre_bank = bank_ff;
      job.row_run  = req_ch.row_end && !trans;
      job.row_len  = new_len;
      job.row_bank = bank_after;
      job.marker   = req_ch.row_end;
      job_push     = accept && (close_pre || req_ch.row_end);

      wr_en   = accept && !trans;
      wr_addr = {bank_after, base_len[IDX_W-1:0]};
      wr_data = req_ch.pixel;

      run_trans_in = run_trans_ff;
      len_in       = len_ff;
      bank_in      = bank_ff;
      if (accept) begin
         run_trans_in = trans;
         if (req_ch.row_end) begin
            len_in  = '0;
            bank_in = trans ? bank_after : ~bank_after;
         end else begin
            len_in  = new_len;
            bank_in = bank_after;
         end
      end

      busy_in = busy_ff;
      if (bank_free.valid) begin
         busy_in[bank_free.bank] = 1'b0;
      end
      if (job_push && opaque_close) begin
         busy_in[bank_ff] = 1'b1;
      end
      if (job_push && job.row_run) begin
         busy_in[bank_after] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_trans_ff <= 1'b0;
         len_ff       <= '0;
         bank_ff      <= 1'b0;
         busy_ff      <= '0;
      end else begin
         run_trans_ff <= run_trans_in;
         len_ff       <= len_in;
         bank_ff      <= bank_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

FILE: design/trle_back.sv
module trle_back import trle_pkg::*; #(
   parameter int BYTES_PER_RESULT = BYTES_DEF,
   parameter int IDX_W            = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  job_type           head_job,
   input  fifo_status_type   q_status,
   output logic              job_pop,
   output bank_free_type     bank_free,
   output logic [IDX_W:0]    rd_addr,
   input  logic [BYTE_W-1:0] rd_data,
   trle_rsp_if.source        rsp_ch
);

   localparam int PACK = (BYTES_PER_RESULT > OUT_BYTES) ? OUT_BYTES : BYTES_PER_RESULT;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PRE_HEAD = 6'b000010,
      ST_PRE_BODY = 6'b000100,
      ST_ROW_HEAD = 6'b001000,
      ST_ROW_BODY = 6'b010000,
      ST_MARK     = 6'b100000
   } state_type;

   function automatic state_type first_state(input job_type j);
      if (j.pre_kind != CLOSE_NONE) begin
         return ST_PRE_HEAD;
      end else if (j.row_run) begin
         return ST_ROW_HEAD;
      end
      return ST_MARK;
   endfunction

   function automatic state_type after_pre(input job_type j);
      if (j.row_run) begin
         return ST_ROW_HEAD;
      end else if (j.marker) begin
         return ST_MARK;
      end
      return ST_IDLE;
   endfunction

   state_type         state_ff, state_in, after;
   job_type           cur_ff, cur_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] pack_ff [OUT_BYTES];
   logic [BYTE_W-1:0] pack_in [OUT_BYTES];
   logic [BYTE_W-1:0] word    [OUT_BYTES];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff [OUT_BYTES];
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_last_ff;

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_val;
   logic              last_px;
   logic              step_end;
   logic              closes;
   logic              advance;
   logic              out_load;
   logic              seg_bank;

   always_comb begin
      byte_valid = 1'b0;
      byte_val   = '0;
      last_px    = 1'b0;
      after      = ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            byte_valid = 1'b0;
         end
         ST_PRE_HEAD: begin
            byte_valid = 1'b1;
            if (cur_ff.pre_kind == CLOSE_TRANS) begin
               byte_val = TRANS_FLAG | {1'b0, cur_ff.pre_len};
               after    = after_pre(cur_ff);
            end else begin
               byte_val = {1'b0, cur_ff.pre_len};
               after    = ST_PRE_BODY;
            end
         end
         ST_PRE_BODY: begin
            byte_valid = 1'b1;
            byte_val   = rd_data;
            last_px    = (LEN_W'(idx_ff) == cur_ff.pre_len - LEN_W'(1));
            after      = last_px ? after_pre(cur_ff) : ST_PRE_BODY;
         end
         ST_ROW_HEAD: begin
            byte_valid = 1'b1;
            byte_val   = {1'b0, cur_ff.row_len};
            after      = ST_ROW_BODY;
         end
         ST_ROW_BODY: begin
            byte_valid = 1'b1;
            byte_val   = rd_data;
            last_px    = (LEN_W'(idx_ff) == cur_ff.row_len - LEN_W'(1));
            after      = last_px ? (cur_ff.marker ? ST_MARK : ST_IDLE) : ST_ROW_BODY;
         end
         ST_MARK: begin
            byte_valid = 1'b1;
            byte_val   = ROW_MARK;
            after      = ST_IDLE;
         end
         default: begin
            byte_valid = 1'b0;
         end
      endcase

      step_end = (after == ST_IDLE);
      closes   = (cnt_ff == CNT_W'(PACK - 1)) || step_end;
      // The byte that completes a word needs the output register free.
      advance  = byte_valid && (!closes || !rsp_valid_ff || rsp_ch.ready);
      out_load = advance && closes;

      state_in = state_ff;
      cur_in   = cur_ff;
      job_pop  = 1'b0;
      if ((state_ff == ST_IDLE) || (advance && step_end)) begin
         if (!q_status.empty) begin
            job_pop  = 1'b1;
            cur_in   = head_job;
            state_in = first_state(head_job);
         end else begin
            state_in = ST_IDLE;
         end
      end else if (advance) begin
         state_in = after;
      end

      idx_in = idx_ff;
      if (advance) begin
         if ((state_ff == ST_PRE_HEAD) || (state_ff == ST_ROW_HEAD)) begin
            idx_in = '0;
         end else if ((state_ff == ST_PRE_BODY) || (state_ff == ST_ROW_BODY)) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      seg_bank = ((state_ff == ST_ROW_HEAD) || (state_ff == ST_ROW_BODY)) ?
                 cur_ff.row_bank : cur_ff.pre_bank;
      // Read one entry ahead so the pixel is registered when its turn comes.
      rd_addr  = {seg_bank, idx_in};

      bank_free.valid = advance && last_px;
      bank_free.bank  = seg_bank;

      for (int i = 0; i < OUT_BYTES; i++) begin
         word[i]    = (cnt_ff == CNT_W'(i)) ? byte_val : pack_ff[i];
         pack_in[i] = pack_ff[i];
         if (advance) begin
            pack_in[i] = closes ? '0 : word[i];
         end
      end
      cnt_in = cnt_ff;
      if (advance) begin
         cnt_in = closes ? '0 : cnt_ff + CNT_W'(1);
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < OUT_BYTES; i++) begin
            pack_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pack_ff      <= pack_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (out_load) begin
         rsp_byte_ff  <= word;
         rsp_count_ff <= cnt_ff + CNT_W'(1);
         rsp_last_ff  <= step_end;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.byte_0     = rsp_byte_ff[0];
   assign rsp_ch.byte_1     = rsp_byte_ff[1];
   assign rsp_ch.byte_2     = rsp_byte_ff[2];
   assign rsp_ch.byte_3     = rsp_byte_ff[3];
   assign rsp_ch.byte_4     = rsp_byte_ff[4];
   assign rsp_ch.byte_5     = rsp_byte_ff[5];
   assign rsp_ch.byte_6     = rsp_byte_ff[6];
   assign rsp_ch.byte_7     = rsp_byte_ff[7];
   assign rsp_ch.byte_count = rsp_count_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

FILE: design/transparent_run_length_encoder_core.sv
// Channel   Direction  Word contents
// req_ch    in         pixel (8), row_end (1)
// rsp_ch    out        byte_0..byte_7 (8 each), byte_count (4), last (1)
//
// The front end takes a pixel per cycle unless the job queue is full or an opaque pixel's
// buffer bank is still being read out. The back end spends a cycle per encoded byte (opaque
// pixels, length and marker bytes), but a byte that ends a word waits until the output register
// is free; a pixel's bytes leave up to BYTES_PER_RESULT (at most OUT_BYTES) to a word through it.
// Reset is synchronous and clears all control state; the pixel buffer needs no clearing.
// An rsp_ch stall holds the back end at a finished word; the front end runs on to a full queue.
module transparent_run_length_encoder_core import trle_pkg::*; #(
   parameter int MAX_RUN          = MAX_RUN_DEF,
   parameter int BYTES_PER_RESULT = BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   trle_req_if.sink   req_ch,
   trle_rsp_if.source rsp_ch
);

   localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam int PACK  = (BYTES_PER_RESULT > OUT_BYTES) ? OUT_BYTES : BYTES_PER_RESULT;

   fifo_status_type   q_status;
   bank_free_type     bank_free;
   job_type           push_job;
   job_type           head_job;
   logic              job_push;
   logic              job_pop;
   logic              wr_en;
   logic [IDX_W:0]    wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [IDX_W:0]    rd_addr;
   logic [BYTE_W-1:0] rd_data;

   trle_front #(
      .MAX_RUN (MAX_RUN),
      .IDX_W   (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_status  (q_status),
      .bank_free (bank_free),
      .job_push  (job_push),
      .job       (push_job),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   trle_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   trle_ram #(
      .IDX_W (IDX_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   trle_back #(
      .BYTES_PER_RESULT (BYTES_PER_RESULT),
      .IDX_W            (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .job_pop   (job_pop),
      .bank_free (bank_free),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_ch    (rsp_ch)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.byte_count != '0) && (rsp_ch.byte_count <= CNT_W'(PACK)))
      else $error("result word byte count out of range");

   // Only the word that ends a pixel's output may be short.
   a_short_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.byte_count != CNT_W'(PACK))) |-> rsp_ch.last)
      else $error("short result word without last");

   a_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_status.full)
      else $error("job queue written while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !q_status.empty)
      else $error("job queue read while empty");

endmodule

FILE: dv/trle_stream_checker.sv
module trle_stream_checker import trle_pkg::*; #(
   parameter int MAX_RUN          = MAX_RUN_DEF,
   parameter int BYTES_PER_RESULT = BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   trle_req_if  req_mon,
   trle_rsp_if  rsp_mon,
   output int   fail_count,
   output int   words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT  = (MAX_RUN < 1) ? 1 : ((MAX_RUN > 127) ? 127 : MAX_RUN);
   localparam int PACK       = (BYTES_PER_RESULT < 1) ? 1 :
                               ((BYTES_PER_RESULT > OUT_BYTES) ? OUT_BYTES : BYTES_PER_RESULT);

   typedef struct packed {
      logic [OUT_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                 count;
      logic                             last;
   } code_word_type;

   logic              run_clear;
   int                run_len;
   logic [BYTE_W-1:0] run_buf [1 << LEN_W];
   logic [BYTE_W-1:0] step_bytes [$];
   code_word_type     coded_words_due [$];

   initial begin
      fail_count = 0;
      words_due  = 0;
      run_clear  = 1'b0;
      run_len    = 0;
   end

   // A transparent run that reaches the row end leaves no byte behind.
   function automatic void close_open_run(input logic at_row_end);
      if (run_len == 0) return;
      if (run_clear) begin
         if (!at_row_end) step_bytes.push_back(TRANS_FLAG + 8'(run_len));
      end else begin
         step_bytes.push_back(8'(run_len));
         for (int i = 0; i < run_len; i++) step_bytes.push_back(run_buf[i]);
      end
      run_len = 0;
   endfunction

   function automatic void encode_pixel(input logic [BYTE_W-1:0] px, input logic ends_row);
      logic          clear;
      int            n;
      int            pos;
      code_word_type w;
      clear = (px == '0);
      step_bytes.delete();
      if (run_len != 0 && (run_clear != clear || run_len >= RUN_LIMIT)) close_open_run(1'b0);
      if (run_len == 0) run_clear = clear;
      run_buf[run_len] = px;
      run_len++;
      if (ends_row) begin
         close_open_run(1'b1);
         step_bytes.push_back(ROW_MARK);
      end
      pos = 0;
      while (pos < step_bytes.size()) begin
         n = step_bytes.size() - pos;
         if (n > PACK) n = PACK;
         w = '0;
         for (int k = 0; k < n; k++) w.bytes[k] = step_bytes[pos + k];
         w.count = CNT_W'(n);
         pos += n;
         w.last = (pos >= step_bytes.size());
         coded_words_due.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      code_word_type got;
      code_word_type want;
      if (reset) begin
         run_clear = 1'b0;
         run_len   = 0;
         coded_words_due.delete();
      end else begin
         // The pixel goes first so that a word it causes at once finds its expectation.
         if (req_mon.valid && req_mon.ready) encode_pixel(req_mon.pixel, req_mon.row_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.bytes = {rsp_mon.byte_7, rsp_mon.byte_6, rsp_mon.byte_5, rsp_mon.byte_4,
                         rsp_mon.byte_3, rsp_mon.byte_2, rsp_mon.byte_1, rsp_mon.byte_0};
            got.count = rsp_mon.byte_count;
            got.last  = rsp_mon.last;
            if (coded_words_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, got bytes %h count %0d last %0d",
                        $time, got.bytes, got.count, got.last);
               fail_count++;
            end else begin
               want = coded_words_due.pop_front();
               if (got !== want) begin
                  $display({"%0t: word mismatch, expected bytes %h count %0d last %0d,",
                            " got bytes %h count %0d last %0d"}, $time, want.bytes,
                           want.count, want.last, got.bytes, got.count, got.last);
                  fail_count++;
               end
            end
         end
      end
      words_due = coded_words_due.size();
   end

endmodule

FILE: dv/transparent_run_length_encoder_core_tb.sv
module transparent_run_length_encoder_core_tb import trle_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIXEL_ITEMS  = 470;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   typedef enum int {
      RX_OPEN     = 0,
      RX_LIGHT    = 1,
      RX_HEAVY    = 2,
      RX_PERIODIC = 3
   } rx_mode_type;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          words_due;
   int          burst_left;
   int          pixels_sent;
   int          cycle_count;
   int          rx_tick;
   rx_mode_type rx_mode;

   trle_req_if req_if ();
   trle_rsp_if rsp_if ();

   transparent_run_length_encoder_core #(
      .MAX_RUN         (MAX_RUN_DEF),
      .BYTES_PER_RESULT(BYTES_DEF)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   trle_stream_checker #(
      .MAX_RUN         (MAX_RUN_DEF),
      .BYTES_PER_RESULT(BYTES_DEF)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .fail_count(fail_count),
      .words_due (words_due)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      rsp_if.ready = 1'b0;
      rx_tick      = 0;
      rx_mode      = RX_OPEN;
      cycle_count  = 0;
   end

   // The receiver switches among four stall behaviors, drawn at random.
   always @(negedge clock) begin
      if (rx_tick % 97 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      rx_tick++;
      case (rx_mode)
         RX_OPEN:  rsp_if.ready <= 1'b1;
         RX_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default:  rsp_if.ready <= ((rx_tick % 11) > 6);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_pixel(input logic [BYTE_W-1:0] px, input logic ends_row);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end
      req_if.valid   <= 1'b1;
      req_if.pixel   <= px;
      req_if.row_end <= ends_row;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      pixels_sent++;
   endtask

   task automatic send_run(input logic clear, input int len, input logic ends_row);
      for (int i = 0; i < len; i++)
         send_pixel(clear ? 8'h00 : 8'($urandom_range(1, 255)), ends_row && (i == len - 1));
   endtask

   initial begin
      int   len;
      int   runs;
      int   roll;
      logic clear;
      req_if.valid   = 1'b0;
      req_if.pixel   = '0;
      req_if.row_end = 1'b0;
      burst_left     = 0;
      pixels_sent    = 0;
      reset          = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One-pixel rows, opaque and transparent.
      send_pixel(8'hff, 1'b1);
      send_pixel(8'h00, 1'b1);
      // Transparent run closed by an opaque pixel.
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h01, 1'b1);
      // Opaque run, then a transparent run dropped at the row end.
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h7f, 1'b0);
      send_pixel(8'h00, 1'b1);
      // Class changes both ways inside one row.
      send_pixel(8'h55, 1'b0);
      send_pixel(8'haa, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h33, 1'b1);
      // Quiet pixels, then a row end whose bytes span two words.
      for (int i = 1; i <= 9; i++) send_pixel(8'(i), i == 9);

      // Hold off until the block has drained everything.
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (words_due != 0) @(negedge clock);

      // Full runs of both classes: each is cut at the run limit and continues.
      send_run(1'b0, 128, 1'b0);
      send_run(1'b1, 129, 1'b0);
      send_run(1'b0, 1, 1'b1);

      while (pixels_sent < PIXEL_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               send_pixel(($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom),
                          (i == len - 1) || ($urandom_range(0, 6) == 0));
         end else begin
            runs  = $urandom_range(1, 4);
            clear = 1'($urandom_range(0, 1));
            for (int r = 0; r < runs; r++) begin
               roll = $urandom_range(0, 99);
               if (roll < 80) len = $urandom_range(1, 6);
               else if (roll < 97) len = $urandom_range(7, 30);
               else len = $urandom_range(120, 135);
               send_run(clear, len, r == runs - 1);
               if ($urandom_range(0, 4) != 0) clear = ~clear;
            end
         end
      end

      req_if.valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && words_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/trle_pkg.sv
design/trle_ifs.sv
design/trle_ram.sv
design/trle_fifo.sv
design/trle_front.sv
design/trle_back.sv
design/transparent_run_length_encoder_core.sv
dv/trle_stream_checker.sv
dv/transparent_run_length_encoder_core_tb.sv
